// ===== rtl/sws_pkg.sv =====
package sws_pkg;

	typedef enum logic [3:0] {
		ST_START, ST_WORD, ST_BSLASH, ST_DOLLAR, ST_SQ, ST_DQ, ST_DQ_BS, ST_ANSI,
		ST_ANSI_BS, ST_CTRL, ST_HEX1, ST_HEX2, ST_OCT, ST_ERR_QUOTE, ST_ERR_META
	} state_t;

	localparam logic [2:0] K_CHAR  = 3'd0;
	localparam logic [2:0] K_END   = 3'd1;
	localparam logic [2:0] K_OK    = 3'd2;
	localparam logic [2:0] K_QUOTE = 3'd3;
	localparam logic [2:0] K_META  = 3'd4;

	localparam logic [15:0] C_BSL = 16'h5C;
	localparam logic [15:0] C_SQ  = 16'h27;
	localparam logic [15:0] C_DQ  = 16'h22;
	localparam logic [15:0] C_DOL = 16'h24;
	localparam logic [15:0] C_BT  = 16'h60;
	localparam logic [15:0] C_EQ  = 16'h3D;
	localparam logic [15:0] C_X   = 16'h78;

	localparam logic [127:0] META_MAP = {
		8'h38, 8'h00, 8'h00, 8'h01, 8'h10, 8'h00, 8'h00, 8'h00,
		8'hd8, 8'h00, 8'h07, 8'hdc, 8'h00, 8'h00, 8'h00, 8'h00};

	localparam int QDEPTH = 4;
	localparam int QAW = 2;

	// one classified item: up to four results
	typedef struct packed {
		logic [2:0]  n;
		logic [3:0][2:0]  kind;
		logic [3:0][15:0] ch;
	} bundle_t;

	function automatic logic is_space(input logic [15:0] c);
		return c == 16'd32 || (c >= 16'd9 && c <= 16'd13) || c == 16'h85 ||
			c == 16'hA0 || c == 16'h1680 || c == 16'h180E ||
			(c >= 16'h2000 && c <= 16'h200A) || c == 16'h2028 ||
			c == 16'h2029 || c == 16'h202F || c == 16'h205F || c == 16'h3000;
	endfunction

	function automatic logic is_meta(input logic [15:0] c);
		return c < 16'd128 && META_MAP[c[6:0]];
	endfunction

	function automatic logic is_name_start(input logic [15:0] c);
		return c == 16'h5F || (c >= 16'h41 && c <= 16'h5A) ||
			(c >= 16'h61 && c <= 16'h7A);
	endfunction

	function automatic logic [4:0] hex_val(input logic [15:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (c >= 16'h30 && c <= 16'h39) r = {1'b0, c[3:0]};
		else if ((c >= 16'h41 && c <= 16'h46) || (c >= 16'h61 && c <= 16'h66))
			r = {1'b0, c[3:0] + 4'd9};
		return r;
	endfunction

endpackage

// ===== rtl/sws_if.sv =====
interface sws_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [15:0] code_point;
	modport source (output valid, mode, code_point, input ready);
	modport sink (input valid, mode, code_point, output ready);
endinterface

interface sws_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [15:0] char_out;
	modport source (output valid, kind, char_out, input ready);
	modport sink (input valid, kind, char_out, output ready);
endinterface

// ===== rtl/sws_front.sv =====
module sws_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              abort_on_meta,
	input  logic              take,
	input  logic              mode,
	input  logic [15:0]       code_point,
	output sws_pkg::bundle_t  bundle
);
	sws_pkg::state_t st_q, st_d;
	logic [8:0] ev_q, ev_d;
	logic [1:0] dc_q, dc_d;
	logic fw_q, fw_d, ac_q, ac_d, err_q, err_d;

	always_comb begin
		sws_pkg::bundle_t b;
		logic [15:0] c;
		logic [4:0] h;
		logic seg, wch, ach, stop;
		logic [15:0] ctl;
		logic [8:0] nv;
		logic [1:0] nc;
		b = '0;
		c = code_point;
		h = sws_pkg::hex_val(c);
		seg = 1'b0; wch = 1'b0; ach = 1'b0; stop = 1'b0;
		ctl = '0; nv = '0; nc = '0;
		st_d = st_q; ev_d = ev_q; dc_d = dc_q; fw_d = fw_q; ac_d = ac_q;
		err_d = err_q;
		if (mode) begin
			if (err_q) begin
				b.kind[0] = (st_q == sws_pkg::ST_ERR_META) ? sws_pkg::K_META : sws_pkg::K_QUOTE;
				b.n = 3'd1;
			end else if (st_q == sws_pkg::ST_START) begin
				b.kind[0] = sws_pkg::K_OK; b.n = 3'd1;
			end else if (st_q == sws_pkg::ST_WORD) begin
				b.kind[0] = sws_pkg::K_END; b.kind[1] = sws_pkg::K_OK; b.n = 3'd2;
			end else if (st_q == sws_pkg::ST_DOLLAR) begin
				if (abort_on_meta) begin
					b.kind[0] = sws_pkg::K_META; b.n = 3'd1;
				end else begin
					b.kind[0] = sws_pkg::K_CHAR; b.ch[0] = sws_pkg::C_DOL;
					b.kind[1] = sws_pkg::K_END; b.kind[2] = sws_pkg::K_OK; b.n = 3'd3;
				end
			end else begin
				b.kind[0] = sws_pkg::K_QUOTE; b.n = 3'd1;
			end
			st_d = sws_pkg::ST_START; ev_d = '0; dc_d = '0; fw_d = 1'b1;
			ac_d = 1'b0; err_d = 1'b0;
		end else if (!err_q) begin
			if (ac_q) begin
				if (c == sws_pkg::C_EQ) begin
					st_d = sws_pkg::ST_ERR_META; err_d = 1'b1; stop = 1'b1;
				end else if (!sws_pkg::is_name_start(c) && !(c >= 16'h30 && c <= 16'h39))
					ac_d = 1'b0;
			end
			if (!stop) begin
				case (st_q)
					sws_pkg::ST_START: begin
						if (!sws_pkg::is_space(c)) begin
							if (abort_on_meta && fw_q && sws_pkg::is_name_start(c)) ac_d = 1'b1;
							seg = 1'b1;
						end
					end
					sws_pkg::ST_WORD: wch = 1'b1;
					sws_pkg::ST_BSLASH: begin
						if (!sws_pkg::is_space(c) && !(abort_on_meta ? sws_pkg::is_meta(c) :
							(c == sws_pkg::C_BSL || c == sws_pkg::C_SQ ||
							c == sws_pkg::C_DQ || c == sws_pkg::C_DOL))) begin
							b.ch[b.n[1:0]] = sws_pkg::C_BSL; b.n = b.n + 3'd1;
						end
						b.ch[b.n[1:0]] = c; b.n = b.n + 3'd1;
						st_d = sws_pkg::ST_WORD;
					end
					sws_pkg::ST_DOLLAR: begin
						if (c == sws_pkg::C_SQ) st_d = sws_pkg::ST_ANSI;
						else if (abort_on_meta) begin
							st_d = sws_pkg::ST_ERR_META; err_d = 1'b1;
						end else begin
							b.ch[0] = sws_pkg::C_DOL; b.n = 3'd1;
							st_d = sws_pkg::ST_WORD; wch = 1'b1;
						end
					end
					sws_pkg::ST_SQ: begin
						if (c == sws_pkg::C_SQ) st_d = sws_pkg::ST_WORD;
						else begin
							b.ch[0] = c; b.n = 3'd1;
						end
					end
					sws_pkg::ST_DQ: begin
						if (c == sws_pkg::C_DQ) st_d = sws_pkg::ST_WORD;
						else if (c == sws_pkg::C_BSL) st_d = sws_pkg::ST_DQ_BS;
						else if (abort_on_meta && (c == sws_pkg::C_DOL || c == sws_pkg::C_BT)) begin
							st_d = sws_pkg::ST_ERR_META; err_d = 1'b1;
						end else begin
							b.ch[0] = c; b.n = 3'd1;
						end
					end
					sws_pkg::ST_DQ_BS: begin
						if (c != sws_pkg::C_DQ && c != sws_pkg::C_BSL &&
							!(abort_on_meta && (c == sws_pkg::C_DOL || c == sws_pkg::C_BT))) begin
							b.ch[0] = sws_pkg::C_BSL; b.n = 3'd1;
						end
						b.ch[b.n[1:0]] = c; b.n = b.n + 3'd1;
						st_d = sws_pkg::ST_DQ;
					end
					sws_pkg::ST_ANSI: ach = 1'b1;
					sws_pkg::ST_ANSI_BS: begin
						st_d = sws_pkg::ST_ANSI;
						b.n = 3'd1;
						case (c)
							16'h61: b.ch[0] = 16'd7;
							16'h62: b.ch[0] = 16'd8;
							16'h65: b.ch[0] = 16'd27;
							16'h66: b.ch[0] = 16'd12;
							16'h6E: b.ch[0] = 16'd10;
							16'h72: b.ch[0] = 16'd13;
							16'h74: b.ch[0] = 16'd9;
							sws_pkg::C_BSL: b.ch[0] = sws_pkg::C_BSL;
							sws_pkg::C_SQ: b.ch[0] = sws_pkg::C_SQ;
							16'h63: begin b.n = 3'd0; st_d = sws_pkg::ST_CTRL; end
							sws_pkg::C_X: begin b.n = 3'd0; st_d = sws_pkg::ST_HEX1; end
							default: begin
								if (c >= 16'h30 && c <= 16'h37) begin
									b.n = 3'd0; ev_d = {6'd0, c[2:0]}; dc_d = 2'd1;
									st_d = sws_pkg::ST_OCT;
								end else begin
									b.ch[0] = sws_pkg::C_BSL; b.ch[1] = c; b.n = 3'd2;
								end
							end
						endcase
					end
					sws_pkg::ST_CTRL: begin
						ctl = (c <= 16'hFF) ? c : 16'd0;
						b.ch[0] = {11'd0, ctl[4:0]}; b.n = 3'd1;
						st_d = sws_pkg::ST_ANSI;
					end
					sws_pkg::ST_HEX1: begin
						if (!h[4]) begin
							ev_d = {5'd0, h[3:0]}; st_d = sws_pkg::ST_HEX2;
						end else begin
							b.ch[0] = sws_pkg::C_BSL; b.ch[1] = sws_pkg::C_X; b.n = 3'd2;
							st_d = sws_pkg::ST_ANSI; ach = 1'b1;
						end
					end
					sws_pkg::ST_HEX2: begin
						st_d = sws_pkg::ST_ANSI;
						b.n = 3'd1;
						if (!h[4]) b.ch[0] = {8'd0, ev_q[3:0], h[3:0]};
						else begin
							b.ch[0] = {7'd0, ev_q}; ach = 1'b1;
						end
					end
					sws_pkg::ST_OCT: begin
						if (c >= 16'h30 && c <= 16'h37) begin
							nv = {ev_q[5:0], c[2:0]};
							nc = dc_q + 2'd1;
							ev_d = nv; dc_d = nc;
							if (nc == 2'd3) begin
								b.ch[0] = {7'd0, nv}; b.n = 3'd1; st_d = sws_pkg::ST_ANSI;
							end
						end else begin
							b.ch[0] = {7'd0, ev_q}; b.n = 3'd1;
							st_d = sws_pkg::ST_ANSI; ach = 1'b1;
						end
					end
					default: begin
						st_d = sws_pkg::ST_ERR_QUOTE; err_d = 1'b1;
					end
				endcase
				if (wch) begin
					if (sws_pkg::is_space(c)) begin
						b.kind[b.n[1:0]] = sws_pkg::K_END; b.ch[b.n[1:0]] = '0;
						b.n = b.n + 3'd1;
						fw_d = 1'b0; st_d = sws_pkg::ST_START;
					end else seg = 1'b1;
				end
				if (seg) begin
					if (c == sws_pkg::C_SQ) st_d = sws_pkg::ST_SQ;
					else if (c == sws_pkg::C_DQ) st_d = sws_pkg::ST_DQ;
					else if (c == sws_pkg::C_DOL) st_d = sws_pkg::ST_DOLLAR;
					else if (c == sws_pkg::C_BSL) st_d = sws_pkg::ST_BSLASH;
					else if (abort_on_meta && sws_pkg::is_meta(c)) begin
						st_d = sws_pkg::ST_ERR_META; err_d = 1'b1;
					end else begin
						b.ch[b.n[1:0]] = c; b.n = b.n + 3'd1; st_d = sws_pkg::ST_WORD;
					end
				end
				if (ach) begin
					if (c == sws_pkg::C_SQ) st_d = sws_pkg::ST_WORD;
					else if (c == sws_pkg::C_BSL) st_d = sws_pkg::ST_ANSI_BS;
					else begin
						b.ch[b.n[1:0]] = c; b.n = b.n + 3'd1;
					end
				end
			end
		end
		bundle = b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= sws_pkg::ST_START; ev_q <= '0; dc_q <= '0; fw_q <= 1'b1;
			ac_q <= 1'b0; err_q <= 1'b0;
		end else if (take) begin
			st_q <= st_d; ev_q <= ev_d; dc_q <= dc_d; fw_q <= fw_d;
			ac_q <= ac_d; err_q <= err_d;
		end
	end
endmodule

// ===== rtl/sws_back.sv =====
module sws_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sws_pkg::bundle_t bundle,
	output logic             full,
	sws_out_if.source        out
);
	sws_pkg::bundle_t mem_q [sws_pkg::QDEPTH];
	logic [sws_pkg::QAW-1:0] wp_q, rp_q;
	logic [sws_pkg::QAW:0] cnt_q;
	logic [1:0] sub_q;
	sws_pkg::bundle_t head;
	logic empty, pop_item, fire;

	assign empty = cnt_q == '0;
	assign head = mem_q[rp_q];
	assign out.valid = !empty;
	assign out.kind = head.kind[sub_q];
	assign out.char_out = head.ch[sub_q];
	assign fire = out.valid && out.ready;
	assign pop_item = fire && ({1'b0, sub_q} + 3'd1 == head.n);
	assign full = cnt_q == sws_pkg::QDEPTH[sws_pkg::QAW:0] && !pop_item;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= bundle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0; sub_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop_item) begin
				rp_q <= rp_q + 1'b1; sub_q <= '0;
			end else if (fire) sub_q <= sub_q + 1'b1;
			cnt_q <= cnt_q + {2'd0, push} - {2'd0, pop_item};
		end
	end
endmodule

// ===== rtl/shell_word_splitter.sv =====
// channel  | dir | fields
// in       | in  | mode, code_point
// out      | out | kind, char_out
// apb      | in  | abort_on_meta at 0x0
// One item per cycle; in.ready drops only when the result queue is full. The
// front parser is a state machine. Each item yields 0..3 results queued as
// one entry (4 entries) and drained one result per cycle while out.ready is
// set; rate is bounded by results, not items. Reset clears parse state.
module shell_word_splitter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	sws_in_if.sink      in,
	sws_out_if.source   out
);
	logic aom_q, full, take;
	sws_pkg::bundle_t bundle;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {31'd0, aom_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) aom_q <= 1'b0;
		else if (psel && penable && pwrite && paddr == 2'd0) aom_q <= pwdata[0];
	end

	assign in.ready = !full;
	assign take = in.valid && !full;

	sws_front u_front (
		.clk, .arst_n, .abort_on_meta(aom_q), .take,
		.mode(in.mode), .code_point(in.code_point), .bundle
	);

	sws_back u_back (
		.clk, .arst_n, .push(take && bundle.n != 3'd0), .bundle, .full, .out
	);
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	typedef struct packed {
		logic        cfg;
		logic        mode;
		logic [15:0] cp;
		logic        chk;
		logic [2:0]  ek;
	} stim_row_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] ch;
	} word_res_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	sws_in_if  in_ch ();
	sws_out_if out_ch ();

	shell_word_splitter u_top (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in(in_ch), .out(out_ch)
	);

	// splitter model state
	sws_pkg::state_t sp_state;
	logic [8:0] sp_esc;
	logic [1:0] sp_digits;
	logic       sp_first, sp_assign, sp_open, sp_err, sp_meta_mode;
	int         sp_nres;

	word_res_t  words_q[$];
	int         fails;
	int         idle_cycles;
	int         burst_left;
	bit         long_hold_req;

	stim_row_t dir_tab [23] = '{
		'{1'b1, 1'b0, 16'd0,           1'b0, sws_pkg::K_CHAR},
		'{1'b0, 1'b1, 16'd0,           1'b1, sws_pkg::K_OK},
		'{1'b0, 1'b0, 16'h61,          1'b1, sws_pkg::K_CHAR},
		'{1'b0, 1'b0, 16'h20,          1'b1, sws_pkg::K_END},
		'{1'b0, 1'b0, 16'hFFFF,        1'b1, sws_pkg::K_CHAR},
		'{1'b0, 1'b1, 16'd0,           1'b1, sws_pkg::K_END},
		'{1'b0, 1'b0, sws_pkg::C_DOL,  1'b0, sws_pkg::K_CHAR},
		'{1'b0, 1'b0, sws_pkg::C_SQ,   1'b0, sws_pkg::K_CHAR},
		'{1'b0, 1'b0, sws_pkg::C_BSL,  1'b0, sws_pkg::K_CHAR},
		'{1'b0, 1'b0, sws_pkg::C_X,    1'b0, sws_pkg::K_CHAR},
		'{1'b0, 1'b0, 16'h34,          1'b0, sws_pkg::K_CHAR},
		'{1'b0, 1'b0, 16'h67,          1'b0, sws_pkg::K_CHAR},
		'{1'b0, 1'b1, 16'hFFFF,        1'b1, sws_pkg::K_QUOTE},
		'{1'b0, 1'b0, sws_pkg::C_BSL,  1'b0, sws_pkg::K_CHAR},
		'{1'b0, 1'b1, 16'd0,           1'b1, sws_pkg::K_QUOTE},
		'{1'b0, 1'b0, sws_pkg::C_DOL,  1'b0, sws_pkg::K_CHAR},
		'{1'b0, 1'b1, 16'd0,           1'b1, sws_pkg::K_CHAR},
		'{1'b1, 1'b0, 16'd1,           1'b0, sws_pkg::K_CHAR},
		'{1'b0, 1'b0, 16'h41,          1'b0, sws_pkg::K_CHAR},
		'{1'b0, 1'b0, sws_pkg::C_EQ,   1'b0, sws_pkg::K_CHAR},
		'{1'b0, 1'b1, 16'd0,           1'b1, sws_pkg::K_META},
		'{1'b0, 1'b0, 16'h3B,          1'b0, sws_pkg::K_CHAR},
		'{1'b0, 1'b1, 16'd0,           1'b1, sws_pkg::K_META}
	};

	function automatic bit ws(input logic [15:0] c);
		return c == 16'd32 || (c >= 16'd9 && c <= 16'd13) || c == 16'h85 || c == 16'hA0 ||
			c == 16'h1680 || c == 16'h180E || (c >= 16'h2000 && c <= 16'h200A) ||
			c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
			c == 16'h3000;
	endfunction

	function automatic bit shell_meta(input logic [15:0] c);
		case (c)
			16'h22, 16'h23, 16'h24, 16'h26, 16'h27, 16'h28, 16'h29, 16'h2A,
			16'h3B, 16'h3C, 16'h3E, 16'h3F, 16'h5C, 16'h60, 16'h7B, 16'h7C,
			16'h7D: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit name_start(input logic [15:0] c);
		return c == 16'h5F || (c >= 16'h41 && c <= 16'h5A) || (c >= 16'h61 && c <= 16'h7A);
	endfunction

	function automatic int hex_digit(input logic [15:0] c);
		if (c >= 16'h30 && c <= 16'h39) return int'(c) - 32'h30;
		if (c >= 16'h41 && c <= 16'h46) return int'(c) - 32'h37;
		if (c >= 16'h61 && c <= 16'h66) return int'(c) - 32'h57;
		return -1;
	endfunction

	function automatic void put_word(input logic [2:0] k, input logic [15:0] c);
		if (sp_nres < 4) begin
			words_q.push_back('{k, c});
			sp_nres++;
		end
	endfunction

	function automatic void latch_err(input sws_pkg::state_t s);
		sp_state = s;
		sp_err = 1'b1;
	endfunction

	function automatic void seg_char(input logic [15:0] c);
		if (c == sws_pkg::C_SQ) sp_state = sws_pkg::ST_SQ;
		else if (c == sws_pkg::C_DQ) sp_state = sws_pkg::ST_DQ;
		else if (c == sws_pkg::C_DOL) sp_state = sws_pkg::ST_DOLLAR;
		else if (c == sws_pkg::C_BSL) sp_state = sws_pkg::ST_BSLASH;
		else if (sp_meta_mode && shell_meta(c)) latch_err(sws_pkg::ST_ERR_META);
		else begin
			put_word(sws_pkg::K_CHAR, c);
			sp_state = sws_pkg::ST_WORD;
		end
	endfunction

	function automatic void in_word(input logic [15:0] c);
		if (ws(c)) begin
			put_word(sws_pkg::K_END, 16'd0);
			sp_open = 1'b0;
			sp_first = 1'b0;
			sp_state = sws_pkg::ST_START;
		end else seg_char(c);
	endfunction

	function automatic void in_ansi(input logic [15:0] c);
		if (c == sws_pkg::C_SQ) sp_state = sws_pkg::ST_WORD;
		else if (c == sws_pkg::C_BSL) sp_state = sws_pkg::ST_ANSI_BS;
		else put_word(sws_pkg::K_CHAR, c);
	endfunction

	function automatic void ansi_esc(input logic [15:0] c);
		sp_state = sws_pkg::ST_ANSI;
		case (c)
			16'h61: put_word(sws_pkg::K_CHAR, 16'd7);
			16'h62: put_word(sws_pkg::K_CHAR, 16'd8);
			16'h65: put_word(sws_pkg::K_CHAR, 16'd27);
			16'h66: put_word(sws_pkg::K_CHAR, 16'd12);
			16'h6E: put_word(sws_pkg::K_CHAR, 16'd10);
			16'h72: put_word(sws_pkg::K_CHAR, 16'd13);
			16'h74: put_word(sws_pkg::K_CHAR, 16'd9);
			sws_pkg::C_BSL: put_word(sws_pkg::K_CHAR, sws_pkg::C_BSL);
			sws_pkg::C_SQ:  put_word(sws_pkg::K_CHAR, sws_pkg::C_SQ);
			16'h63: sp_state = sws_pkg::ST_CTRL;
			sws_pkg::C_X: sp_state = sws_pkg::ST_HEX1;
			default: begin
				if (c >= 16'h30 && c <= 16'h37) begin
					sp_esc = 9'(c - 16'h30);
					sp_digits = 2'd1;
					sp_state = sws_pkg::ST_OCT;
				end else begin
					put_word(sws_pkg::K_CHAR, sws_pkg::C_BSL);
					put_word(sws_pkg::K_CHAR, c);
				end
			end
		endcase
	endfunction

	function automatic void parse_char(input logic [15:0] c);
		int h;
		case (sp_state)
			sws_pkg::ST_START: begin
				if (!ws(c)) begin
					sp_open = 1'b1;
					if (sp_meta_mode && sp_first && name_start(c)) sp_assign = 1'b1;
					seg_char(c);
				end
			end
			sws_pkg::ST_WORD: in_word(c);
			sws_pkg::ST_BSLASH: begin
				if (!ws(c) && !(sp_meta_mode ? shell_meta(c) :
					(c == sws_pkg::C_BSL || c == sws_pkg::C_SQ || c == sws_pkg::C_DQ ||
					c == sws_pkg::C_DOL)))
					put_word(sws_pkg::K_CHAR, sws_pkg::C_BSL);
				put_word(sws_pkg::K_CHAR, c);
				sp_state = sws_pkg::ST_WORD;
			end
			sws_pkg::ST_DOLLAR: begin
				if (c == sws_pkg::C_SQ) sp_state = sws_pkg::ST_ANSI;
				else if (sp_meta_mode) latch_err(sws_pkg::ST_ERR_META);
				else begin
					put_word(sws_pkg::K_CHAR, sws_pkg::C_DOL);
					sp_state = sws_pkg::ST_WORD;
					in_word(c);
				end
			end
			sws_pkg::ST_SQ: begin
				if (c == sws_pkg::C_SQ) sp_state = sws_pkg::ST_WORD;
				else put_word(sws_pkg::K_CHAR, c);
			end
			sws_pkg::ST_DQ: begin
				if (c == sws_pkg::C_DQ) sp_state = sws_pkg::ST_WORD;
				else if (c == sws_pkg::C_BSL) sp_state = sws_pkg::ST_DQ_BS;
				else if (sp_meta_mode && (c == sws_pkg::C_DOL || c == sws_pkg::C_BT))
					latch_err(sws_pkg::ST_ERR_META);
				else put_word(sws_pkg::K_CHAR, c);
			end
			sws_pkg::ST_DQ_BS: begin
				if (c != sws_pkg::C_DQ && c != sws_pkg::C_BSL &&
					!(sp_meta_mode && (c == sws_pkg::C_DOL || c == sws_pkg::C_BT)))
					put_word(sws_pkg::K_CHAR, sws_pkg::C_BSL);
				put_word(sws_pkg::K_CHAR, c);
				sp_state = sws_pkg::ST_DQ;
			end
			sws_pkg::ST_ANSI: in_ansi(c);
			sws_pkg::ST_ANSI_BS: ansi_esc(c);
			sws_pkg::ST_CTRL: begin
				put_word(sws_pkg::K_CHAR, (c <= 16'hFF ? c : 16'd0) & 16'd31);
				sp_state = sws_pkg::ST_ANSI;
			end
			sws_pkg::ST_HEX1: begin
				h = hex_digit(c);
				if (h >= 0) begin
					sp_esc = 9'(h);
					sp_state = sws_pkg::ST_HEX2;
				end else begin
					put_word(sws_pkg::K_CHAR, sws_pkg::C_BSL);
					put_word(sws_pkg::K_CHAR, sws_pkg::C_X);
					sp_state = sws_pkg::ST_ANSI;
					in_ansi(c);
				end
			end
			sws_pkg::ST_HEX2: begin
				h = hex_digit(c);
				sp_state = sws_pkg::ST_ANSI;
				if (h >= 0) put_word(sws_pkg::K_CHAR, 16'(sp_esc * 16 + h));
				else begin
					put_word(sws_pkg::K_CHAR, 16'(sp_esc));
					in_ansi(c);
				end
			end
			sws_pkg::ST_OCT: begin
				if (c >= 16'h30 && c <= 16'h37) begin
					sp_esc = 9'(sp_esc * 8 + (c - 16'h30));
					sp_digits = sp_digits + 2'd1;
					if (sp_digits == 2'd3) begin
						put_word(sws_pkg::K_CHAR, 16'(sp_esc));
						sp_state = sws_pkg::ST_ANSI;
					end
				end else begin
					put_word(sws_pkg::K_CHAR, 16'(sp_esc));
					sp_state = sws_pkg::ST_ANSI;
					in_ansi(c);
				end
			end
			default: latch_err(sws_pkg::ST_ERR_QUOTE);
		endcase
	endfunction

	function automatic void clear_line();
		sp_state = sws_pkg::ST_START;
		sp_esc = '0;
		sp_digits = '0;
		sp_first = 1'b1;
		sp_assign = 1'b0;
		sp_open = 1'b0;
		sp_err = 1'b0;
	endfunction

	// returns kind of first new result, or 7 if none
	function automatic logic [2:0] split_item(input logic m, input logic [15:0] c);
		int base;
		base = words_q.size();
		sp_nres = 0;
		if (m) begin
			if (sp_err)
				put_word(sp_state == sws_pkg::ST_ERR_META ? sws_pkg::K_META : sws_pkg::K_QUOTE,
					16'd0);
			else if (sp_state == sws_pkg::ST_START) put_word(sws_pkg::K_OK, 16'd0);
			else if (sp_state == sws_pkg::ST_WORD) begin
				put_word(sws_pkg::K_END, 16'd0);
				put_word(sws_pkg::K_OK, 16'd0);
			end else if (sp_state == sws_pkg::ST_DOLLAR) begin
				if (sp_meta_mode) put_word(sws_pkg::K_META, 16'd0);
				else begin
					put_word(sws_pkg::K_CHAR, sws_pkg::C_DOL);
					put_word(sws_pkg::K_END, 16'd0);
					put_word(sws_pkg::K_OK, 16'd0);
				end
			end else put_word(sws_pkg::K_QUOTE, 16'd0);
			clear_line();
		end else if (!sp_err) begin
			if (sp_assign && c == sws_pkg::C_EQ) latch_err(sws_pkg::ST_ERR_META);
			else begin
				if (sp_assign && !name_start(c) && !(c >= 16'h30 && c <= 16'h39))
					sp_assign = 1'b0;
				parse_char(c);
			end
		end
		return words_q.size() > base ? words_q[base].kind : 3'd7;
	endfunction

	task automatic report(input string what, input int a, input int b);
		fails++;
		$display("mismatch %s: got %0h expected %0h at %0t", what, a, b, $realtime);
	endtask

	task automatic send_item(input logic m, input logic [15:0] c, output logic [2:0] k1);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 10);
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode <= m;
		in_ch.code_point <= c;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		k1 = split_item(m, c);
		burst_left--;
	endtask

	task automatic write_cfg(input logic v);
		in_ch.valid <= 1'b0;
		burst_left = 0;
		while (words_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 2'd0;
		pwdata <= {31'd0, v};
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sp_meta_mode = v;
	endtask

	function automatic logic [15:0] pick_char();
		logic [15:0] spc [8] = '{16'd9, 16'd13, 16'h85, 16'hA0, 16'h1680, 16'h2005,
			16'h3000, 16'h202F};
		logic [15:0] esc [9] = '{16'h61, 16'h62, 16'h65, 16'h66, 16'h6E, 16'h72,
			16'h74, 16'h63, sws_pkg::C_X};
		logic [15:0] mch [8] = '{16'h3B, 16'h26, 16'h7C, 16'h3C, 16'h2A, 16'h23,
			sws_pkg::C_BT, 16'h7D};
		case ($urandom_range(0, 15))
			0, 1: return 16'($urandom_range(16'h61, 16'h7A));
			2: return 16'h20;
			3: return spc[$urandom_range(0, 7)];
			4: return sws_pkg::C_SQ;
			5: return sws_pkg::C_DQ;
			6: return sws_pkg::C_BSL;
			7: return sws_pkg::C_DOL;
			8: return esc[$urandom_range(0, 8)];
			9: return 16'($urandom_range(16'h30, 16'h39));
			10: return $urandom_range(0, 1) ? 16'($urandom_range(16'h41, 16'h46)) :
				sws_pkg::C_EQ;
			11: return mch[$urandom_range(0, 7)];
			12: return 16'($urandom_range(0, 16'hFFFF));
			13: return 16'($urandom_range(16'h100, 16'hFFFF));
			14: return 16'h5F;
			default: return 16'($urandom_range(0, 16'hFF));
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver stall pattern
	initial begin
		int hold, phase_len;
		bit full_rate;
		hold = 0;
		phase_len = 0;
		full_rate = 1'b0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = 300;
			end
			if (phase_len == 0) begin
				phase_len = $urandom_range(10, 60);
				full_rate = $urandom_range(0, 1);
			end
			phase_len--;
			if (hold > 0) begin
				hold--;
				out_ch.ready <= 1'b0;
			end else out_ch.ready <= full_rate || ($urandom_range(0, 2) != 0);
		end
	end

	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) begin
			if (words_q.size() == 0) report("unexpected result kind", out_ch.kind, 0);
			else begin
				if (out_ch.kind !== words_q[0].kind)
					report("kind", out_ch.kind, words_q[0].kind);
				if (out_ch.char_out !== words_q[0].ch)
					report("char_out", out_ch.char_out, words_q[0].ch);
				void'(words_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles > 5000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		logic [2:0] k1;
		logic [15:0] c;
		int sent, len;
		fails = 0;
		idle_cycles = 0;
		burst_left = 0;
		long_hold_req = 1'b0;
		arst_n = 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.mode <= 1'b0;
		in_ch.code_point <= '0;
		sp_meta_mode = 1'b0;
		clear_line();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].cfg) write_cfg(dir_tab[i].cp[0]);
			else begin
				send_item(dir_tab[i].mode, dir_tab[i].cp, k1);
				if (dir_tab[i].chk && k1 !== dir_tab[i].ek)
					report("directed kind", k1, dir_tab[i].ek);
			end
		end

		for (int ph = 0; ph < 3; ph++) begin
			write_cfg(ph == 1);
			if (ph == 1) long_hold_req = 1'b1;
			sent = 0;
			while (sent < 36) begin
				if ($urandom_range(0, 9) == 0) begin
					send_item(1'($urandom_range(0, 1)), 16'($urandom_range(0, 16'hFFFF)), k1);
					sent++;
				end else begin
					len = $urandom_range(1, 12);
					if ($urandom_range(0, 2) == 0) begin
						send_item(1'b0, sws_pkg::C_DOL, k1);
						send_item(1'b0, sws_pkg::C_SQ, k1);
						sent += 2;
					end
					repeat (len) begin
						c = pick_char();
						send_item(1'b0, c, k1);
						sent++;
					end
					send_item(1'b1, 16'($urandom_range(0, 16'hFFFF)), k1);
					sent++;
				end
			end
		end

		in_ch.valid <= 1'b0;
		while (words_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== shell_word_splitter.f =====
rtl/sws_pkg.sv
rtl/sws_if.sv
rtl/sws_front.sv
rtl/sws_back.sv
rtl/shell_word_splitter.sv
dv/tb_top.sv
